@@ design/bitwise_scatter_combine_buffer_unit_defines.svh @@
// assertion macros used by the port-level checker
`ifndef BITWISE_SCATTER_COMBINE_BUFFER_UNIT_DEFINES_SVH
`define BITWISE_SCATTER_COMBINE_BUFFER_UNIT_DEFINES_SVH

// antecedent in the same cycle implies the consequent
`define BSCB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bscb check failed");

// condition must never hold
`define BSCB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bscb check failed");

`endif

@@ design/bscb_pkg.sv @@
// shared types, codes and word functions of the scatter combine buffer
package bscb_pkg;

  localparam int MEM_DEPTH_DEF = 65536;
  localparam int BUF_DEPTH_DEF = 1024;

  localparam int OFF_W      = 16;
  localparam int OFF_SPAN   = 1 << OFF_W;
  localparam int VAL_W      = 64;
  localparam int REQ_W      = 3;
  localparam int OP_W       = 2;
  localparam int SLOTS_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 17;
  localparam int KIND_W     = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_COMMIT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

  localparam logic [OP_W-1:0] OP_OR  = 2'd0;
  localparam logic [OP_W-1:0] OP_AND = 2'd1;
  localparam logic [OP_W-1:0] OP_XOR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_SELECT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_WORDS   = 2'd2;

  localparam logic [OP_W-1:0]    OP_RESET    = OP_OR;
  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 11'd1024;
  localparam logic               WIDE_RESET  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NOP      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DISABLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COMBINE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIRECT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COMMIT   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd7;

  typedef logic [VAL_W-1:0] word_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             wide;
    logic [CNT_W-1:0] active;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  mem_off;
    logic [OFF_W-1:0]  slot;
    word_t             value;
  } cmd_t;

  function automatic word_t word_mask(logic wide);
    return wide ? {VAL_W{1'b1}} : {{(VAL_W-32){1'b0}}, {32{1'b1}}};
  endfunction

  function automatic word_t op_identity(logic [OP_W-1:0] op, logic wide);
    return (op == OP_AND) ? word_mask(wide) : '0;
  endfunction

  function automatic word_t op_combine(logic [OP_W-1:0] op, word_t a, word_t b);
    word_t res;
    case (op)
      OP_AND:  res = a & b;
      OP_XOR:  res = a ^ b;
      default: res = a | b;
    endcase
    return res;
  endfunction

endpackage

@@ design/bscb_front.sv @@
// front stage: accepts requests, reduces the offset into memory range, classifies
module bscb_front #(
  parameter int MEM_DEPTH = bscb_pkg::MEM_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bscb_pkg::cfg_t              cfg,
  input  logic                        start,
  output logic                        busy,
  input  logic [bscb_pkg::REQ_W-1:0]  in_req_type,
  input  logic [bscb_pkg::OFF_W-1:0]  in_slot_offset,
  input  logic [bscb_pkg::VAL_W-1:0]  in_operand_value,
  input  logic                        in_lane_enable,
  input  logic                        clearing,
  input  logic                        queue_full,
  output logic                        push,
  output bscb_pkg::cmd_t              push_cmd
);
  import bscb_pkg::*;

  localparam int QB = (MEM_DEPTH >= OFF_SPAN) ? 0 :
                      $clog2((OFF_SPAN + MEM_DEPTH - 1) / MEM_DEPTH);
  localparam int RC_W = $clog2(QB + 2);
  localparam int RED_PER_CYC = 4;
  localparam int DIV0 = MEM_DEPTH * (2 ** ((QB > 0) ? QB - 1 : 0));

  logic                stg_v_r, stg_v_nxt;
  logic [REQ_W-1:0]    req_r;
  logic [OFF_W-1:0]    off_r;
  word_t               val_r;
  logic                en_r;
  logic [OFF_W-1:0]    rem_r, rem_nxt;
  logic [OFF_W-1:0]    div_r, div_nxt;
  logic [RC_W-1:0]     cnt_r, cnt_nxt;
  logic                accept;
  logic [KIND_W-1:0]   kind;

  assign push   = stg_v_r && (cnt_r == '0) && !queue_full;
  assign busy   = clearing || (stg_v_r && !push);
  assign accept = start && !busy;

  // a few restoring subtract steps per cycle
  always_comb begin
    logic [OFF_W-1:0] r;
    logic [OFF_W-1:0] d;
    r = rem_r;
    d = div_r;
    for (int j = 0; j < RED_PER_CYC; j++) begin
      if (j < int'(cnt_r)) begin
        if (r >= d) begin
          r = r - d;
        end
        d = d >> 1;
      end
    end
    rem_nxt = r;
    div_nxt = d;
    cnt_nxt = (int'(cnt_r) > RED_PER_CYC) ? cnt_r - RC_W'(RED_PER_CYC) : '0;
  end

  always_comb begin
    case (req_r)
      REQ_BEGIN:  kind = KIND_BEGIN;
      REQ_UPDATE: begin
        if (!en_r) begin
          kind = KIND_DISABLED;
        end else if (CNT_W'(off_r) < cfg.active) begin
          kind = KIND_COMBINE;
        end else begin
          kind = KIND_DIRECT;
        end
      end
      REQ_COMMIT: kind = KIND_COMMIT;
      REQ_WRITE:  kind = KIND_WRITE;
      REQ_READ:   kind = KIND_READ;
      default:    kind = KIND_NOP;
    endcase
  end

  assign push_cmd = '{kind: kind, mem_off: rem_r, slot: off_r, value: val_r};

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (accept) begin
      stg_v_nxt = 1'b1;
    end else if (push) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      off_r <= in_slot_offset;
      val_r <= in_operand_value & word_mask(cfg.wide);
      en_r  <= in_lane_enable;
      rem_r <= in_slot_offset;
      div_r <= OFF_W'(DIV0);
      cnt_r <= RC_W'(QB);
    end else begin
      rem_r <= rem_nxt;
      div_r <= div_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/bscb_fifo.sv @@
// short command queue between the front and back stages
module bscb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bscb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bscb_pkg::cmd_t head
);
  import bscb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/bscb_back.sv @@
// back stage: word memory, combining slots and the sequencer that executes commands
module bscb_back #(
  parameter int MEM_DEPTH = bscb_pkg::MEM_DEPTH_DEF,
  parameter int BUF_DEPTH = bscb_pkg::BUF_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bscb_pkg::cfg_t             cfg,
  input  logic                       cmd_valid,
  input  bscb_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  output logic                       clearing,
  output logic                       res_valid,
  output logic [bscb_pkg::VAL_W-1:0] res_old,
  output logic                       res_direct
);
  import bscb_pkg::*;

  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int BUF_AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int IDX_W  = $clog2(BUF_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_CRD  = 3'd3;
  localparam logic [2:0] ST_CWB  = 3'd4;

  word_t              mem_r  [MEM_DEPTH];
  word_t              slot_r [BUF_DEPTH];
  word_t              mem_rdata_r, slot_rdata_r;

  logic [2:0]         state_r, state_nxt;
  cmd_t               cur_r, cur_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [MEM_AW-1:0]  caddr_r, caddr_nxt;
  word_t              fill_val_r, fill_val_nxt;
  logic               fill_emit_r, fill_emit_nxt;
  logic               res_valid_r, res_valid_nxt;
  word_t              res_old_r, res_old_nxt;
  logic               res_dir_r, res_dir_nxt;

  logic [MEM_AW-1:0]  mem_raddr, mem_waddr;
  logic [BUF_AW-1:0]  slot_raddr, slot_waddr;
  logic               mem_we, slot_we;
  word_t              mem_wdata, slot_wdata;
  word_t              wm, id, old_word, contrib;

  assign wm       = word_mask(cfg.wide);
  assign id       = op_identity(cfg.op, cfg.wide);
  assign old_word = mem_rdata_r & wm;
  assign contrib  = slot_rdata_r & wm;

  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;
  assign clearing = (state_r == ST_FILL) && !fill_emit_r;

  assign mem_raddr  = (state_r == ST_CRD) ? caddr_r : MEM_AW'(cmd.mem_off);
  assign slot_raddr = (state_r == ST_CRD) ? idx_r[BUF_AW-1:0] : BUF_AW'(cmd.slot);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    caddr_nxt     = caddr_r;
    fill_val_nxt  = fill_val_r;
    fill_emit_nxt = fill_emit_r;
    res_valid_nxt = 1'b0;
    res_old_nxt   = '0;
    res_dir_nxt   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = MEM_AW'(cmd.mem_off);
    mem_wdata     = cmd.value;
    slot_we       = 1'b0;
    slot_waddr    = idx_r[BUF_AW-1:0];
    slot_wdata    = fill_val_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          case (cmd.kind)
            KIND_BEGIN: begin
              fill_val_nxt  = id;
              fill_emit_nxt = 1'b1;
              idx_nxt       = '0;
              state_nxt     = ST_FILL;
            end
            KIND_DISABLED: begin
              res_valid_nxt = 1'b1;
              res_old_nxt   = wm;
            end
            KIND_COMBINE, KIND_DIRECT, KIND_READ: begin
              state_nxt = ST_UPD;
            end
            KIND_COMMIT: begin
              if (cfg.active == '0) begin
                res_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                caddr_nxt = '0;
                state_nxt = ST_CRD;
              end
            end
            KIND_WRITE: begin
              mem_we        = 1'b1;
              res_valid_nxt = 1'b1;
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        slot_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(BUF_DEPTH - 1)) begin
          state_nxt     = ST_IDLE;
          res_valid_nxt = fill_emit_r;
        end
      end
      ST_UPD: begin
        res_valid_nxt = 1'b1;
        res_old_nxt   = old_word;
        if (cur_r.kind == KIND_DIRECT) begin
          mem_we      = 1'b1;
          mem_waddr   = MEM_AW'(cur_r.mem_off);
          mem_wdata   = op_combine(cfg.op, old_word, cur_r.value) & wm;
          res_dir_nxt = 1'b1;
        end else if (cur_r.kind == KIND_COMBINE) begin
          slot_we    = 1'b1;
          slot_waddr = BUF_AW'(cur_r.slot);
          slot_wdata = op_combine(cfg.op, contrib, cur_r.value) & wm;
        end
        state_nxt = ST_IDLE;
      end
      ST_CRD: begin
        state_nxt = ST_CWB;
      end
      ST_CWB: begin
        if (contrib != id) begin
          mem_we    = 1'b1;
          mem_waddr = caddr_r;
          mem_wdata = op_combine(cfg.op, old_word, contrib) & wm;
        end
        idx_nxt   = idx_r + 1'b1;
        caddr_nxt = (caddr_r == MEM_AW'(MEM_DEPTH - 1)) ? '0 : caddr_r + 1'b1;
        if (CNT_W'(idx_r) + CNT_W'(1) == cfg.active) begin
          state_nxt     = ST_IDLE;
          res_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_CRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      idx_r       <= '0;
      fill_val_r  <= '0;
      fill_emit_r <= 1'b0;
      res_valid_r <= 1'b0;
      res_dir_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_val_r  <= fill_val_nxt;
      fill_emit_r <= fill_emit_nxt;
      res_valid_r <= res_valid_nxt;
      res_dir_r   <= res_dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    caddr_r   <= caddr_nxt;
    res_old_r <= res_old_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_r[slot_waddr] <= slot_wdata;
    end
    slot_rdata_r <= slot_r[slot_raddr];
  end

  assign res_valid  = res_valid_r;
  assign res_old    = res_old_r;
  assign res_direct = res_dir_r;

endmodule

@@ design/bitwise_scatter_combine_buffer_unit.sv @@
// top level of the bitwise scatter combine buffer unit
// A request is taken when start is high and busy is low; every request gives exactly one
// result, shown for one cycle with out_valid, in request order, and the receiver cannot
// stall it. A front stage reduces the offset into memory range (restoring subtraction of
// q quotient bits when MEM_DEPTH is below 65536) and queues up to two requests ahead of
// the back stage, which owns the word memory and combining slots (one read and one write
// port each). The back stage finishes a lane update or read before it takes the next
// command; disabled lanes, writes and unused codes it retires one per cycle while queued.
// Begin fills every slot at one per cycle; commit merges each active slot into memory.
// After reset busy stays high while the slots are cleared. The user must write the
// configuration through the cfg port only while idle; the block does not enforce this.
module bitwise_scatter_combine_buffer_unit #(
  parameter int MEM_DEPTH = bscb_pkg::MEM_DEPTH_DEF,
  parameter int BUF_DEPTH = bscb_pkg::BUF_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bscb_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bscb_pkg::OFF_W-1:0]      in_slot_offset,
  input  logic [bscb_pkg::VAL_W-1:0]      in_operand_value,
  input  logic                            in_lane_enable,
  output logic                            out_valid,
  output logic [bscb_pkg::VAL_W-1:0]      out_old_value,
  output logic                            out_direct_path,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bscb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bscb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bscb_pkg::*;

  logic [OP_W-1:0]    op_r;
  logic [SLOTS_W-1:0] slots_r;
  logic               wide_r;
  cfg_t               cfg_bus;

  logic               clearing, queue_full, push, pop, not_empty;
  cmd_t               push_cmd, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_RESET;
      slots_r <= SLOTS_RESET;
      wide_r  <= WIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OP_SELECT:    op_r    <= cfg_wdata[OP_W-1:0];
        CFG_SLOTS_IN_USE: slots_r <= cfg_wdata[SLOTS_W-1:0];
        CFG_WIDE_WORDS:   wide_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_bus.op     = op_r;
  assign cfg_bus.wide   = wide_r;
  assign cfg_bus.active = (CNT_W'(slots_r) > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH)
                                                                : CNT_W'(slots_r);

  bscb_front #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_bus),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_slot_offset   (in_slot_offset),
    .in_operand_value (in_operand_value),
    .in_lane_enable   (in_lane_enable),
    .clearing         (clearing),
    .queue_full       (queue_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  bscb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  bscb_back #(
    .MEM_DEPTH(MEM_DEPTH),
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_bus),
    .cmd_valid  (not_empty),
    .cmd        (head),
    .cmd_pop    (pop),
    .clearing   (clearing),
    .res_valid  (out_valid),
    .res_old    (out_old_value),
    .res_direct (out_direct_path)
  );

endmodule

@@ design/bscb_checker.sv @@
// port-level checker for the scatter combine buffer unit and its bind
`include "bitwise_scatter_combine_buffer_unit_defines.svh"

module bscb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_direct_path
);

  localparam int PEND_W   = 3;
  localparam int PEND_MAX = 5;

  logic              accept;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  assign accept = start && !busy;

  always_comb begin
    pend_nxt = pend_r;
    if (accept && !out_valid) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_valid && !accept) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `BSCB_ASSERT_IMPL(a_direct_only_with_result, clk, rst_n, out_direct_path, out_valid)
  `BSCB_ASSERT_IMPL(a_busy_after_reset, clk, rst_n, !$past(rst_n), busy)
  `BSCB_ASSERT_IMPL(a_result_has_transaction, clk, rst_n, out_valid, pend_r != '0)
  `BSCB_ASSERT_NEVER(a_pending_bounded, clk, rst_n, pend_r > PEND_W'(PEND_MAX))

endmodule

bind bitwise_scatter_combine_buffer_unit bscb_checker u_bscb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_direct_path (out_direct_path)
);
